// ----- design/bvm_pkg.sv -----
// bvm_pkg: shared widths, codes and stage payload types for the battery voltage monitor.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package bvm_pkg;

  localparam int DATA_W    = 12;  // ADC sample, readings and register width
  localparam int SUM_W     = 16;  // block sum, holds 16 * 4095
  localparam int IDX_W     = 4;   // sample index within a block
  localparam int CNT_W     = 8;   // wrapping event counters
  localparam int CFG_IDX_W = 3;   // register index on the config channel

  localparam int SAMPLES_DEF        = 10;
  localparam int SHUTDOWN_COUNT_DEF = 5;
  localparam int UNDER_COUNT_DEF    = 5;
  localparam int ADC_BITS_DEF       = 12;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_UNSTABLE = 2'd1,
    ST_UNDER    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_MIN        = 3'd0,
    REG_ADC_MAX        = 3'd1,
    REG_DIFF_MIN       = 3'd2,
    REG_DIFF_MAX       = 3'd3,
    REG_SHUTDOWN_LEVEL = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] adc_min;
    logic [DATA_W-1:0] adc_max;
    logic [DATA_W-1:0] diff_min;
    logic [DATA_W-1:0] diff_max;
    logic [DATA_W-1:0] shutdown_level;
  } cfg_t;

  // trimmed block sum on its way to the divider
  typedef struct packed {
    logic [SUM_W-1:0] trim;
    logic             on_battery;
    logic             display_on;
  } blk_t;

  // trimmed mean, masked to register width
  typedef struct packed {
    logic [DATA_W-1:0] mean;
    logic              on_battery;
    logic              display_on;
  } mean_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] level;
    logic              shutdown_request;
  } res_t;

endpackage

// ----- design/bvm_ifs.sv -----
// bvm_ifs: valid/ready channel interfaces for samples, results and register writes.
// Depends on bvm_pkg for field widths.
`timescale 1ns / 1ps

interface bvm_sample_if;
  logic                       valid;
  logic                       ready;
  logic [bvm_pkg::DATA_W-1:0] adc_sample;
  logic                       on_battery;
  logic                       display_on;

  modport source (output valid, adc_sample, on_battery, display_on, input ready);
  modport sink   (input valid, adc_sample, on_battery, display_on, output ready);
endinterface

interface bvm_result_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [bvm_pkg::DATA_W-1:0] level;
  logic                       shutdown_request;

  modport source (output valid, status, level, shutdown_request, input ready);
  modport sink   (input valid, status, level, shutdown_request, output ready);
endinterface

interface bvm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bvm_pkg::CFG_IDX_W-1:0] index;
  logic [bvm_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/bvm_cfg.sv -----
// bvm_cfg: configuration register file, written one register per transaction.
// Depends on bvm_pkg (cfg_t, cfg_reg_t).
`timescale 1ns / 1ps

module bvm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_valid,
  output logic                            wr_ready,
  input  logic [bvm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [bvm_pkg::DATA_W-1:0]      wr_data,
  output bvm_pkg::cfg_t                   cfg
);

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_min        <= '0;
      cfg.adc_max        <= '1;
      cfg.diff_min       <= '0;
      cfg.diff_max       <= bvm_pkg::DATA_W'(3);
      cfg.shutdown_level <= '0;
    end else if (wr_valid && wr_ready) begin
      unique case (bvm_pkg::cfg_reg_t'(wr_index))
        bvm_pkg::REG_ADC_MIN:        cfg.adc_min        <= wr_data;
        bvm_pkg::REG_ADC_MAX:        cfg.adc_max        <= wr_data;
        bvm_pkg::REG_DIFF_MIN:       cfg.diff_min       <= wr_data;
        bvm_pkg::REG_DIFF_MAX:       cfg.diff_max       <= wr_data;
        bvm_pkg::REG_SHUTDOWN_LEVEL: cfg.shutdown_level <= wr_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

// ----- design/bvm_accum.sv -----
// bvm_accum: per-block running sum, maximum and minimum; emits the trimmed sum
// on the last sample of each block. Depends on bvm_pkg (blk_t, widths).
`timescale 1ns / 1ps

module bvm_accum #(
  parameter int SAMPLES  = bvm_pkg::SAMPLES_DEF,
  parameter int ADC_BITS = bvm_pkg::ADC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bvm_pkg::DATA_W-1:0] adc_sample,
  input  logic                       on_battery,
  input  logic                       display_on,
  output logic                       blk_valid,
  output bvm_pkg::blk_t              blk,
  input  logic                       blk_ready
);

  localparam int DW = bvm_pkg::DATA_W;
  localparam int SW = bvm_pkg::SUM_W;
  localparam logic [DW-1:0] SampleMask =
    (ADC_BITS >= DW) ? {DW{1'b1}} : DW'((1 << ADC_BITS) - 1);
  localparam logic [bvm_pkg::IDX_W-1:0] LastIdx = bvm_pkg::IDX_W'(SAMPLES - 1);

  logic [SW-1:0]             sample_sum;
  logic [DW-1:0]             sample_max;
  logic [DW-1:0]             sample_min;
  logic [bvm_pkg::IDX_W-1:0] sample_index;

  logic [DW-1:0] s;
  logic [SW-1:0] sum_next;
  logic [DW-1:0] max_next;
  logic [DW-1:0] min_next;
  logic          last;
  logic          accept;

  assign last     = (sample_index == LastIdx);
  // only the closing sample needs room downstream
  assign in_ready = !last || !blk_valid || blk_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    s        = adc_sample & SampleMask;
    sum_next = sample_sum + SW'(s);
    max_next = (s > sample_max) ? s : sample_max;
    min_next = (s < sample_min) ? s : sample_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_max   <= '0;
      sample_min   <= SampleMask;
      sample_index <= '0;
      blk_valid    <= 1'b0;
    end else begin
      if (accept) begin
        if (last) begin
          sample_sum   <= '0;
          sample_max   <= '0;
          sample_min   <= SampleMask;
          sample_index <= '0;
        end else begin
          sample_sum   <= sum_next;
          sample_max   <= max_next;
          sample_min   <= min_next;
          sample_index <= sample_index + 1'b1;
        end
      end
      if (accept && last) begin
        blk_valid <= 1'b1;
      end else if (blk_ready) begin
        blk_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      blk.trim       <= sum_next - SW'(max_next) - SW'(min_next);
      blk.on_battery <= on_battery;
      blk.display_on <= display_on;
    end
  end

endmodule

// ----- design/bvm_div.sv -----
// bvm_div: divides the trimmed sum by SAMPLES-2 through an exact reciprocal multiply.
// Depends on bvm_pkg (blk_t, mean_t, widths).
`timescale 1ns / 1ps

module bvm_div #(
  parameter int SAMPLES = bvm_pkg::SAMPLES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           blk_valid,
  output logic           blk_ready,
  input  bvm_pkg::blk_t  blk,
  output logic           mean_valid,
  output bvm_pkg::mean_t mean,
  input  logic           mean_ready
);

  localparam int SW         = bvm_pkg::SUM_W;
  localparam int TrimDiv    = SAMPLES - 2;
  localparam int RecipShift = SW + $clog2(TrimDiv);
  localparam int RecipW     = SW + 1;
  localparam int ProdW      = SW + RecipW;
  // ceil(2^(N+l)/d) gives floor(x/d) exactly for every N-bit x
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(TrimDiv) - 64'd1) / 64'(TrimDiv));

  logic [ProdW-1:0] product;

  assign blk_ready = !mean_valid || mean_ready;
  assign product   = ProdW'(blk.trim) * ProdW'(Recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (blk_valid && blk_ready) begin
      mean_valid <= 1'b1;
    end else if (mean_ready) begin
      mean_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_valid && blk_ready) begin
      mean.mean       <= bvm_pkg::DATA_W'(product >> RecipShift);
      mean.on_battery <= blk.on_battery;
      mean.display_on <= blk.display_on;
    end
  end

endmodule

// ----- design/bvm_eval.sv -----
// bvm_eval: clamps the mean into slot A or B, checks the pair for stability and
// the average for low voltage, and holds the result register. Depends on bvm_pkg.
`timescale 1ns / 1ps

module bvm_eval #(
  parameter int SHUTDOWN_COUNT = bvm_pkg::SHUTDOWN_COUNT_DEF,
  parameter int UNDER_COUNT    = bvm_pkg::UNDER_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  bvm_pkg::cfg_t  cfg,
  input  logic           mean_valid,
  output logic           mean_ready,
  input  bvm_pkg::mean_t mean,
  output logic           res_valid,
  output bvm_pkg::res_t  res,
  input  logic           res_ready
);

  localparam int DW = bvm_pkg::DATA_W;
  localparam int CW = bvm_pkg::CNT_W;

  logic [DW-1:0] reading_a;
  logic [DW-1:0] reading_b;
  logic          slot_select;
  logic [CW-1:0] low_count;
  logic [CW-1:0] under_count;
  logic          rd_valid;
  logic          rd_on_battery;
  logic          rd_display_on;

  logic          rd_ready;
  logic          mean_fire;
  logic          rd_fire;
  logic [DW-1:0] clamped;
  logic [DW:0]   pair_sum;
  logic [DW-1:0] avg;
  logic [DW-1:0] diff;
  logic [CW-1:0] low_count_next;
  logic [CW-1:0] under_count_next;
  bvm_pkg::res_t res_next;

  assign rd_ready   = !res_valid || res_ready;
  assign mean_ready = !rd_valid || rd_ready;
  assign mean_fire  = mean_valid && mean_ready;
  assign rd_fire    = rd_valid && rd_ready;

  // with an inverted window, anything at or above adc_min lands on adc_max
  always_comb begin
    if (mean.mean >= cfg.adc_min && mean.mean <= cfg.adc_max) begin
      clamped = mean.mean;
    end else if (mean.mean > cfg.adc_max) begin
      clamped = cfg.adc_max;
    end else begin
      clamped = cfg.adc_min;
    end
  end

  always_comb begin
    pair_sum         = {1'b0, reading_a} + {1'b0, reading_b};
    avg              = pair_sum[DW:1];
    diff             = (reading_a >= reading_b) ? reading_a - reading_b
                                                : reading_b - reading_a;
    low_count_next   = low_count;
    under_count_next = under_count;
    res_next.status           = bvm_pkg::ST_VALID;
    res_next.level            = avg;
    res_next.shutdown_request = 1'b0;
    if (diff < cfg.diff_min || diff > cfg.diff_max) begin
      res_next.status = bvm_pkg::ST_UNSTABLE;
      res_next.level  = '0;
    end else if (rd_display_on) begin
      if (avg >= cfg.adc_min && avg <= cfg.adc_max) begin
        if (rd_on_battery && avg < cfg.shutdown_level) begin
          low_count_next            = low_count + 1'b1;
          res_next.shutdown_request = (low_count_next == CW'(SHUTDOWN_COUNT));
        end
      end else if (avg > cfg.adc_max) begin
        res_next.level = cfg.adc_max;
      end else begin
        under_count_next = under_count + 1'b1;
        if (under_count_next > CW'(UNDER_COUNT)) begin
          under_count_next          = '0;
          res_next.shutdown_request = 1'b1;
        end
        res_next.status = bvm_pkg::ST_UNDER;
        res_next.level  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_a   <= '0;
      reading_b   <= '0;
      slot_select <= 1'b0;
      low_count   <= '0;
      under_count <= '0;
      rd_valid    <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (mean_fire) begin
        if (!slot_select) begin
          reading_a <= clamped;
        end else begin
          reading_b <= clamped;
        end
        slot_select <= !slot_select;
      end
      if (mean_fire) begin
        rd_valid <= 1'b1;
      end else if (rd_ready) begin
        rd_valid <= 1'b0;
      end
      if (rd_fire) begin
        low_count   <= low_count_next;
        under_count <= under_count_next;
        res_valid   <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mean_fire) begin
      rd_on_battery <= mean.on_battery;
      rd_display_on <= mean.display_on;
    end
    if (rd_fire) begin
      res <= res_next;
    end
  end

endmodule

// ----- design/battery_voltage_monitor.sv -----
// Battery voltage monitor. Takes one ADC sample per cycle on the sample channel, with no
// stalls except when the closing sample of a block meets a full pipeline. Every SAMPLES
// samples it forms the trimmed mean (sum less largest and smallest, divided by SAMPLES-2
// through a reciprocal multiply), alternates it into readings A and B, and delivers one
// result transaction: status, averaged level and a shutdown request. The result passes
// four registers (trimmed sum, multiply, reading update, result register) on the way to the
// result channel. The rate is set by the single add/compare accumulator.
// Register writes are taken every cycle and belong only to idle periods.
`timescale 1ns / 1ps

module battery_voltage_monitor #(
  parameter int SAMPLES        = bvm_pkg::SAMPLES_DEF,
  parameter int SHUTDOWN_COUNT = bvm_pkg::SHUTDOWN_COUNT_DEF,
  parameter int UNDER_COUNT    = bvm_pkg::UNDER_COUNT_DEF,
  parameter int ADC_BITS       = bvm_pkg::ADC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bvm_sample_if.sink    samp,
  bvm_result_if.source  result,
  bvm_cfg_if.sink       cfg
);

  bvm_pkg::cfg_t  cfg_regs;
  bvm_pkg::blk_t  blk;
  bvm_pkg::mean_t mean;
  bvm_pkg::res_t  res;
  logic           blk_valid;
  logic           blk_ready;
  logic           mean_valid;
  logic           mean_ready;

  bvm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  bvm_accum #(
    .SAMPLES  (SAMPLES),
    .ADC_BITS (ADC_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (samp.valid),
    .in_ready   (samp.ready),
    .adc_sample (samp.adc_sample),
    .on_battery (samp.on_battery),
    .display_on (samp.display_on),
    .blk_valid  (blk_valid),
    .blk        (blk),
    .blk_ready  (blk_ready)
  );

  bvm_div #(
    .SAMPLES (SAMPLES)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .blk_valid  (blk_valid),
    .blk_ready  (blk_ready),
    .blk        (blk),
    .mean_valid (mean_valid),
    .mean       (mean),
    .mean_ready (mean_ready)
  );

  bvm_eval #(
    .SHUTDOWN_COUNT (SHUTDOWN_COUNT),
    .UNDER_COUNT    (UNDER_COUNT)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .mean_valid (mean_valid),
    .mean_ready (mean_ready),
    .mean       (mean),
    .res_valid  (result.valid),
    .res        (res),
    .res_ready  (result.ready)
  );

  assign result.status           = res.status;
  assign result.level            = res.level;
  assign result.shutdown_request = res.shutdown_request;

endmodule

// ----- design/bvm_checker.sv -----
// bvm_checker: port-level assertions on the result channel of the monitor,
// attached to battery_voltage_monitor by bind. Depends on bvm_pkg for status codes.
`timescale 1ns / 1ps

module bvm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [bvm_pkg::DATA_W-1:0] out_level,
  input logic                       out_req
);

  // a stalled result transaction holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_level) && $stable(out_req))
    else $error("result changed while stalled");

  a_unstable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == bvm_pkg::ST_UNSTABLE |-> out_level == '0 && !out_req)
    else $error("unstable result carries level or shutdown request");

  a_under: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == bvm_pkg::ST_UNDER |-> out_level == '0)
    else $error("undervoltage result carries a level");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind battery_voltage_monitor bvm_checker u_bvm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_status (result.status),
  .out_level  (result.level),
  .out_req    (result.shutdown_request)
);

// ----- bench/tb.sv -----
// tb: self-checking bench for battery_voltage_monitor, driven over the sample, result and
// register channels. Depends on bvm_pkg and the channel interfaces in bvm_ifs.
`timescale 1ns / 1ps

module tb;

  localparam int SAMPLES        = bvm_pkg::SAMPLES_DEF;
  localparam int SHUTDOWN_COUNT = bvm_pkg::SHUTDOWN_COUNT_DEF;
  localparam int UNDER_COUNT    = bvm_pkg::UNDER_COUNT_DEF;
  localparam int ADC_BITS       = bvm_pkg::ADC_BITS_DEF;
  localparam int DW             = bvm_pkg::DATA_W;
  localparam int ADC_FULL       = (1 << DW) - 1;
  localparam int TRIM_DIV       = (SAMPLES > 2) ? SAMPLES - 2 : 1;
  localparam logic [DW-1:0] SAMPLE_MASK = DW'((1 << ADC_BITS) - 1);
  localparam int PIPE_FLUSH     = 8;
  localparam int CYCLE_LIMIT    = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bvm_sample_if samp_if ();
  bvm_result_if result_if ();
  bvm_cfg_if    cfg_if ();

  battery_voltage_monitor i_dut (
    .clk    (clk),
    .rst    (rst),
    .samp   (samp_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always #10 clk = ~clk;

  // predictor state, mirrors the block after reset
  bvm_pkg::cfg_t             regs = '{adc_min: 12'd0, adc_max: 12'hFFF, diff_min: 12'd0,
                                      diff_max: 12'd3, shutdown_level: 12'd0};
  logic [bvm_pkg::SUM_W-1:0] blk_sum = '0;
  logic [DW-1:0]             blk_max = '0;
  logic [DW-1:0]             blk_min = SAMPLE_MASK;
  int unsigned               blk_idx = 0;
  logic [DW-1:0]             reading_a = '0;
  logic [DW-1:0]             reading_b = '0;
  logic                      slot_b = 1'b0;
  logic [bvm_pkg::CNT_W-1:0] low_count = '0;
  logic [bvm_pkg::CNT_W-1:0] under_count = '0;

  bvm_pkg::res_t pending_results[$];
  bvm_pkg::res_t got_expected;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            idling = 1'b1;
  int            sink_hold = 0;

  function automatic logic [DW-1:0] clamp_mean(logic [DW-1:0] m);
    if (m >= regs.adc_min && m <= regs.adc_max) return m;
    if (m > regs.adc_max) return regs.adc_max;
    return regs.adc_min;
  endfunction

  // accumulates one sample; on the closing sample of a block queues the expected result
  function automatic void track_sample(logic [DW-1:0] raw, logic batt, logic disp);
    logic [DW-1:0] s;
    logic [DW-1:0] mean;
    logic [DW-1:0] avg;
    logic [DW-1:0] diff;
    int unsigned   trimmed;
    bvm_pkg::res_t r;
    s = raw & SAMPLE_MASK;
    blk_sum = blk_sum + s;
    if (s > blk_max) blk_max = s;
    if (s < blk_min) blk_min = s;
    if (blk_idx + 1 < SAMPLES) begin
      blk_idx = blk_idx + 1;
      return;
    end
    trimmed = 32'(blk_sum) - 32'(blk_max) - 32'(blk_min);
    mean = DW'(trimmed / TRIM_DIV);
    blk_sum = '0;
    blk_max = '0;
    blk_min = SAMPLE_MASK;
    blk_idx = 0;
    mean = clamp_mean(mean);
    if (!slot_b) reading_a = mean;
    else reading_b = mean;
    slot_b = !slot_b;
    diff = (reading_a >= reading_b) ? reading_a - reading_b : reading_b - reading_a;
    r.status = bvm_pkg::ST_VALID;
    r.level = '0;
    r.shutdown_request = 1'b0;
    if (diff < regs.diff_min || diff > regs.diff_max) begin
      r.status = bvm_pkg::ST_UNSTABLE;
    end else begin
      avg = DW'((32'(reading_a) + 32'(reading_b)) >> 1);
      r.level = avg;
      if (disp) begin
        if (avg >= regs.adc_min && avg <= regs.adc_max) begin
          if (batt && avg < regs.shutdown_level) begin
            low_count = low_count + 1'b1;
            if (low_count == SHUTDOWN_COUNT) r.shutdown_request = 1'b1;
          end
        end else if (avg > regs.adc_max) begin
          r.level = regs.adc_max;
        end else begin
          under_count = under_count + 1'b1;
          if (under_count > UNDER_COUNT) begin
            under_count = '0;
            r.shutdown_request = 1'b1;
          end
          r.status = bvm_pkg::ST_UNDER;
          r.level = '0;
        end
      end
    end
    pending_results.push_back(r);
  endfunction

  // monitors
  always @(posedge clk) begin
    if (!rst && samp_if.valid && samp_if.ready)
      track_sample(samp_if.adc_sample, samp_if.on_battery, samp_if.display_on);
  end

  always @(posedge clk) begin
    if (!rst && cfg_if.valid && cfg_if.ready) begin
      case (bvm_pkg::cfg_reg_t'(cfg_if.index))
        bvm_pkg::REG_ADC_MIN:        regs.adc_min = cfg_if.data;
        bvm_pkg::REG_ADC_MAX:        regs.adc_max = cfg_if.data;
        bvm_pkg::REG_DIFF_MIN:       regs.diff_min = cfg_if.data;
        bvm_pkg::REG_DIFF_MAX:       regs.diff_max = cfg_if.data;
        bvm_pkg::REG_SHUTDOWN_LEVEL: regs.shutdown_level = cfg_if.data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d level %0d shutdown_request %0d",
               result_if.status, result_if.level, result_if.shutdown_request);
        mismatch_count++;
      end else begin
        got_expected = pending_results.pop_front();
        if (result_if.status !== got_expected.status) begin
          $error("status: expected %0d, actual %0d", got_expected.status, result_if.status);
          mismatch_count++;
        end
        if (result_if.level !== got_expected.level) begin
          $error("level: expected %0d, actual %0d", got_expected.level, result_if.level);
          mismatch_count++;
        end
        if (result_if.shutdown_request !== got_expected.shutdown_request) begin
          $error("shutdown_request: expected %0d, actual %0d",
                 got_expected.shutdown_request, result_if.shutdown_request);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones; always zero while idling is clear
  function automatic int pick_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: long hold-off on request, otherwise random stalls
  initial begin : result_sink
    int stall;
    stall = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        result_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic send_sample(input logic [DW-1:0] value, input logic batt,
                             input logic disp);
    int gap;
    samp_if.valid      <= 1'b1;
    samp_if.adc_sample <= value;
    samp_if.on_battery <= batt;
    samp_if.display_on <= disp;
    do @(posedge clk); while (!samp_if.ready);
    gap = pick_gap();
    if (gap > 0) begin
      samp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [DW-1:0] sample_near(int centre, int spread);
    int v;
    if ($urandom_range(0, 9) == 0) return DW'($urandom_range(0, ADC_FULL));
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > ADC_FULL) v = ADC_FULL;
    return DW'(v);
  endfunction

  // blocks of samples scattered around a drifting battery level, outliers included
  task automatic run_levels(input int blocks, input int start, input int drift,
                            input int spread, input int batt_pct, input int disp_pct);
    int centre;
    centre = start;
    for (int b = 0; b < blocks; b++) begin
      centre = centre + int'($urandom_range(0, 2 * drift)) - drift;
      if (centre < 0) centre = 0;
      if (centre > ADC_FULL) centre = ADC_FULL;
      for (int k = 0; k < SAMPLES; k++)
        send_sample(sample_near(centre, spread), $urandom_range(0, 99) < batt_pct,
                    $urandom_range(0, 99) < disp_pct);
    end
  endtask

  task automatic send_noise(input int count);
    for (int k = 0; k < count; k++)
      send_sample(DW'($urandom_range(0, ADC_FULL)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    samp_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  task automatic write_reg(input bvm_pkg::cfg_reg_t idx, input logic [DW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int lo, input int hi, input int dmin, input int dmax,
                          input int shut);
    write_reg(bvm_pkg::REG_ADC_MIN, DW'(lo));
    write_reg(bvm_pkg::REG_ADC_MAX, DW'(hi));
    write_reg(bvm_pkg::REG_DIFF_MIN, DW'(dmin));
    write_reg(bvm_pkg::REG_DIFF_MAX, DW'(dmax));
    write_reg(bvm_pkg::REG_SHUTDOWN_LEVEL, DW'(shut));
  endtask

  // reset settings: first reading is compared against the empty slot B, then a jump
  task automatic test_first_pair();
    send_sample(DW'(ADC_FULL), 1'b0, 1'b0);
    send_sample('0, 1'b0, 1'b0);
    for (int k = 2; k < SAMPLES; k++)
      send_sample(DW'(2), 1'b1, 1'b1);
    for (int k = 0; k < SAMPLES; k++)
      send_sample(DW'(ADC_FULL), 1'b1, 1'b0);
    wait_idle();
  endtask

  task automatic test_stable_levels();
    set_regs(0, ADC_FULL, 0, ADC_FULL, 0);
    idling = 1'b0;
    run_levels(6, 2048, 800, 300, 50, 50);
    idling = 1'b1;
    run_levels(6, 2048, 800, 300, 50, 50);
    wait_idle();
  endtask

  task automatic test_low_battery_shutdown();
    set_regs(0, ADC_FULL, 0, ADC_FULL, 3000);
    run_levels(10, 1500, 200, 40, 90, 90);
    wait_idle();
  endtask

  task automatic test_diff_window();
    set_regs(0, ADC_FULL, 4, 40, 2000);
    run_levels(5, 1800, 30, 20, 50, 80);
    wait_idle();
  endtask

  // adc_min above adc_max: means land on one of the two bounds, mostly undervoltage
  task automatic test_inverted_window();
    set_regs(3000, 1000, 0, ADC_FULL, 2500);
    run_levels(12, 2000, 1500, 100, 50, 90);
    wait_idle();
  endtask

  task automatic test_random_settings();
    for (int round = 0; round < 3; round++) begin
      if (round == 1)
        set_regs($urandom_range(0, ADC_FULL), $urandom_range(0, ADC_FULL),
                 $urandom_range(0, ADC_FULL), $urandom_range(0, ADC_FULL),
                 $urandom_range(0, ADC_FULL));
      else
        set_regs($urandom_range(0, 1500), $urandom_range(2500, ADC_FULL),
                 $urandom_range(0, 20), $urandom_range(20, 400),
                 $urandom_range(0, ADC_FULL));
      if (round == 0) begin
        // result side blocked while samples keep coming: pipeline backs up into the input
        sink_hold = 300;
        idling = 1'b0;
        run_levels(8, 2000, 300, 60, 50, 70);
        idling = 1'b1;
      end
      run_levels(4, $urandom_range(0, ADC_FULL), 300, 60, 50, 70);
      send_noise($urandom_range(3, 17));
      if (round == 2) wait_idle();
      run_levels(4, $urandom_range(0, ADC_FULL), 300, 60, 50, 70);
      wait_idle();
    end
  endtask

  task automatic test_register_extremes();
    set_regs(ADC_FULL, ADC_FULL, ADC_FULL, ADC_FULL, ADC_FULL);
    run_levels(3, 2048, 1000, 500, 50, 70);
    wait_idle();
    set_regs(0, 0, 0, 0, 0);
    run_levels(3, 2048, 1000, 500, 50, 70);
    wait_idle();
    set_regs(0, ADC_FULL, 0, 0, ADC_FULL);
    run_levels(3, 1000, 0, 0, 80, 80);
    wait_idle();
  endtask

  initial begin
    samp_if.valid      = 1'b0;
    samp_if.adc_sample = '0;
    samp_if.on_battery = 1'b0;
    samp_if.display_on = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = bvm_pkg::REG_ADC_MIN;
    cfg_if.data        = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_pair();
    test_stable_levels();
    test_low_battery_shutdown();
    test_diff_window();
    test_inverted_window();
    test_random_settings();
    test_register_extremes();
    wait_idle();

    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
